>>> design/sbfd_pkg.sv
// Shared types and constants for the sensor beacon frame decoder.
// Holds the beat and result structs, type codes and range limits.
// No dependencies.
`default_nettype none

package sbfd_pkg;

  localparam int MAX_FRAME_BYTES = 31;
  localparam int COUNT_CAP_INT   = (MAX_FRAME_BYTES < 31) ? MAX_FRAME_BYTES : 31;
  localparam logic [4:0] COUNT_CAP = COUNT_CAP_INT[4:0];

  localparam int CAP_DEPTH = 14;
  localparam logic [4:0] CAP_FIRST = 5'd5;
  localparam logic [4:0] CAP_END   = 5'd19;

  localparam logic [4:0] LEN_ADDR   = 5'd12;
  localparam logic [4:0] LEN_DECODE = 5'd16;
  localparam logic [4:0] LEN_WORD   = 5'd17;
  localparam logic [4:0] LEN_LUX    = 5'd18;
  localparam logic [4:0] LEN_PAIR   = 5'd19;

  localparam logic [7:0] TYPE_TEMP  = 8'd4;
  localparam logic [7:0] TYPE_HUMI  = 8'd6;
  localparam logic [7:0] TYPE_LUX   = 8'd7;
  localparam logic [7:0] TYPE_MOIST = 8'd8;
  localparam logic [7:0] TYPE_COND  = 8'd9;
  localparam logic [7:0] TYPE_BATT  = 8'd10;
  localparam logic [7:0] TYPE_PAIR  = 8'd13;
  localparam logic [7:0] TYPE_FORM  = 8'd16;

  localparam logic signed [15:0] TEMP_LO    = -16'sd300;
  localparam logic signed [15:0] TEMP_HI    = 16'sd1000;
  localparam logic signed [15:0] HUMI_HI    = 16'sd1000;
  localparam logic signed [15:0] MOIST_HI   = 16'sd100;
  localparam logic signed [15:0] COND_LIM   = 16'sd20000;
  localparam logic signed [15:0] FORM_HI    = 16'sd1000;
  localparam logic signed [15:0] CLIMATE_LO = -16'sd990;
  localparam logic [23:0]        LUX_LIM    = 24'd150000;

  localparam int KB_TEMP  = 0;
  localparam int KB_HUMI  = 1;
  localparam int KB_LUX   = 2;
  localparam int KB_MOIST = 3;
  localparam int KB_COND  = 4;
  localparam int KB_FORM  = 5;
  localparam int KB_BATT  = 6;
  localparam int KB_ADDR  = 7;

  localparam int TDATA_W = 152;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [47:0]        addr;
    logic signed [15:0] temp;
    logic signed [15:0] humi;
    logic [17:0]        lux;
    logic [6:0]         moist;
    logic [14:0]        cond;
    logic [9:0]         form;
    logic signed [7:0]  batt;
    logic [7:0]         known;
    logic               changed;
    logic               ready;
  } result_t;

endpackage

`default_nettype wire

>>> design/sbfd_in_stage.sv
// Input register stage of the sensor beacon frame decoder.
// Holds one accepted beat until the decode core consumes it; uses sbfd_pkg.
`default_nettype none

module sbfd_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sbfd_pkg::beat_t in_beat,
  input  wire logic          take,
  output logic               beat_valid,
  output sbfd_pkg::beat_t    beat
);
  import sbfd_pkg::*;

  logic  vld_r, vld_nxt;
  beat_t beat_r;

  assign in_ready   = !vld_r || take;
  assign beat_valid = vld_r;
  assign beat       = beat_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

`default_nettype wire

>>> design/sbfd_core.sv
// Frame state and decode core: byte count, capture bytes, stored values.
// Produces the result of a frame-ending beat combinationally; uses sbfd_pkg.
`default_nettype none

module sbfd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire sbfd_pkg::beat_t beat,
  output sbfd_pkg::result_t    res
);
  import sbfd_pkg::*;

  logic [4:0]         count_r, count_nxt;
  logic [7:0]         cap_r [CAP_DEPTH];
  logic [7:0]         view [CAP_DEPTH];
  logic [47:0]        addr_r, addr_nxt;
  logic signed [15:0] temp_r, temp_nxt;
  logic signed [15:0] humi_r, humi_nxt;
  logic [17:0]        lux_r, lux_nxt;
  logic [6:0]         moist_r, moist_nxt;
  logic [14:0]        cond_r, cond_nxt;
  logic [9:0]         form_r, form_nxt;
  logic signed [7:0]  batt_r, batt_nxt;
  logic [7:0]         known_r, known_nxt;

  logic               below_cap;
  logic               cap_we;
  logic [4:0]         cap_off;
  logic [3:0]         cap_idx;
  logic [4:0]         len;
  logic [7:0]         t;
  logic signed [15:0] v;
  logic signed [15:0] h;
  logic [23:0]        lx;
  logic               changed;
  logic               ready;

  assign below_cap = count_r < COUNT_CAP;
  assign cap_we    = below_cap && count_r >= CAP_FIRST && count_r < CAP_END;
  assign cap_off   = count_r - CAP_FIRST;
  assign cap_idx   = cap_off[3:0];
  assign len       = below_cap ? count_r + 5'd1 : count_r;

  // current beat folded into the capture view
  always_comb begin
    for (int i = 0; i < CAP_DEPTH; i++) begin
      view[i] = (cap_we && cap_idx == 4'(i)) ? beat.data : cap_r[i];
    end
  end

  assign t  = view[7];
  assign v  = {view[11], view[10]};
  assign h  = {view[13], view[12]};
  assign lx = {view[12], view[11], view[10]};

  always_comb begin
    count_nxt = count_r;
    addr_nxt  = addr_r;
    temp_nxt  = temp_r;
    humi_nxt  = humi_r;
    lux_nxt   = lux_r;
    moist_nxt = moist_r;
    cond_nxt  = cond_r;
    form_nxt  = form_r;
    batt_nxt  = batt_r;
    known_nxt = known_r;
    changed   = 1'b0;
    ready     = 1'b0;

    if (step) begin
      if (beat.last) begin
        count_nxt = '0;
      end else if (below_cap) begin
        count_nxt = count_r + 5'd1;
      end
    end

    if (step && beat.last && len >= LEN_ADDR) begin
      if (!known_r[KB_ADDR]) begin
        addr_nxt           = {view[5], view[4], view[3], view[2], view[1], view[0]};
        known_nxt[KB_ADDR] = 1'b1;
      end
      if (len >= LEN_DECODE) begin
        case (t)
          TYPE_TEMP: begin
            if (len >= LEN_WORD && (!known_r[KB_TEMP] || temp_r != v) &&
                v > TEMP_LO && v < TEMP_HI) begin
              changed            = 1'b1;
              temp_nxt           = v;
              known_nxt[KB_TEMP] = 1'b1;
            end
          end
          TYPE_HUMI: begin
            if (len >= LEN_WORD && (!known_r[KB_HUMI] || humi_r != v) &&
                v >= 16'sd0 && v <= HUMI_HI) begin
              changed            = 1'b1;
              humi_nxt           = v;
              known_nxt[KB_HUMI] = 1'b1;
            end
          end
          TYPE_LUX: begin
            if (len >= LEN_LUX && (!known_r[KB_LUX] || lux_r != lx[17:0]) &&
                lx < LUX_LIM) begin
              changed           = 1'b1;
              lux_nxt           = lx[17:0];
              known_nxt[KB_LUX] = 1'b1;
            end
          end
          TYPE_MOIST: begin
            if (len >= LEN_WORD && (!known_r[KB_MOIST] || moist_r != v[6:0]) &&
                v >= 16'sd0 && v <= MOIST_HI) begin
              changed             = 1'b1;
              moist_nxt           = v[6:0];
              known_nxt[KB_MOIST] = 1'b1;
            end
          end
          TYPE_COND: begin
            if (len >= LEN_WORD && (!known_r[KB_COND] || cond_r != v[14:0]) &&
                v >= 16'sd0 && v < COND_LIM) begin
              changed            = 1'b1;
              cond_nxt           = v[14:0];
              known_nxt[KB_COND] = 1'b1;
            end
          end
          TYPE_BATT: begin
            batt_nxt           = view[10];
            known_nxt[KB_BATT] = 1'b1;
          end
          TYPE_PAIR: begin
            if (len >= LEN_PAIR) begin
              if (!known_r[KB_TEMP] || temp_r != v) begin
                changed            = 1'b1;
                temp_nxt           = v;
                known_nxt[KB_TEMP] = 1'b1;
              end
              if (!known_r[KB_HUMI] || humi_r != h) begin
                changed            = 1'b1;
                humi_nxt           = h;
                known_nxt[KB_HUMI] = 1'b1;
              end
            end
          end
          TYPE_FORM: begin
            if (len >= LEN_WORD && (!known_r[KB_FORM] || form_r != v[9:0]) &&
                v >= 16'sd0 && v <= FORM_HI) begin
              changed            = 1'b1;
              form_nxt           = v[9:0];
              known_nxt[KB_FORM] = 1'b1;
            end
          end
          default: begin
          end
        endcase
        ready = known_nxt[KB_TEMP] && known_nxt[KB_HUMI] &&
                temp_nxt > CLIMATE_LO && humi_nxt > CLIMATE_LO;
      end
    end
  end

  always_comb begin
    res.addr    = addr_nxt;
    res.temp    = temp_nxt;
    res.humi    = humi_nxt;
    res.lux     = lux_nxt;
    res.moist   = moist_nxt;
    res.cond    = cond_nxt;
    res.form    = form_nxt;
    res.batt    = batt_nxt;
    res.known   = known_nxt;
    res.changed = changed;
    res.ready   = ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      addr_r  <= '0;
      temp_r  <= '0;
      humi_r  <= '0;
      lux_r   <= '0;
      moist_r <= '0;
      cond_r  <= '0;
      form_r  <= '0;
      batt_r  <= '0;
      known_r <= '0;
    end else begin
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      temp_r  <= temp_nxt;
      humi_r  <= humi_nxt;
      lux_r   <= lux_nxt;
      moist_r <= moist_nxt;
      cond_r  <= cond_nxt;
      form_r  <= form_nxt;
      batt_r  <= batt_nxt;
      known_r <= known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cap_we) begin
      cap_r[cap_idx] <= beat.data;
    end
  end

endmodule

`default_nettype wire

>>> design/sensor_beacon_frame_decoder_unit.sv
// Top level of the sensor beacon frame decoder: input stage, decode core,
// result register. Depends on sbfd_pkg, sbfd_in_stage and sbfd_core.
//
//   channel | ports                      | beat
//   in      | in_tvalid/tready/tdata/tlast | one payload byte, tlast on frame end
//   out     | out_tvalid/tready/tdata    | one result per frame end
//
// One beat per cycle while no frame end waits; a beat is registered in the
// input stage, and a frame end decodes combinationally into the result register.
// Non-final bytes never wait on the result side; a frame end waits only while
// the result register is full and not taken.
// Synchronous active-low reset clears count, stored values and known mask.
`default_nettype none

module sensor_beacon_frame_decoder_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,   // [7:0] payload_byte
  input  wire logic           in_tlast,   // frame_end
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [sbfd_pkg::TDATA_W-1:0] out_tdata
  // out_tdata from bit 0: device_address[47:0], temperature_tenths[63:48],
  // humidity_tenths[79:64], illuminance_lux[97:80], soil_moisture[104:98],
  // soil_conductivity[119:105], formaldehyde_tenths[129:120],
  // battery_level[137:130], known_mask[145:138], values_changed[146],
  // climate_ready[147], zero[151:148]
);
  import sbfd_pkg::*;

  beat_t   in_beat;
  beat_t   beat;
  logic    beat_valid;
  logic    step;
  logic    out_free;
  result_t res;
  result_t res_r;
  logic    out_vld_r, out_vld_nxt;

  assign in_beat.data = in_tdata;
  assign in_beat.last = in_tlast;

  assign out_free = !out_vld_r || out_tready;
  assign step     = beat_valid && (!beat.last || out_free);

  sbfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_beat    (in_beat),
    .take       (step),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  sbfd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .beat  (beat),
    .res   (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step && beat.last) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && beat.last) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, res_r.ready, res_r.changed, res_r.known, res_r.batt,
                       res_r.form, res_r.cond, res_r.moist, res_r.lux, res_r.humi,
                       res_r.temp, res_r.addr};

endmodule

`default_nettype wire
